### hdl/dmpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmpd_pkg;

    localparam int GAIN_W   = 8;
    localparam int SPEED_W  = 16;
    localparam int DRIVE_W  = 16;
    localparam int DUTY_W   = 15;
    localparam int MODE_W   = 3;
    localparam int DIST_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Error is one bit wider than the inputs, the change of error one more
    localparam int ERR_W    = SPEED_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int PROD_P_W = ERR_W + GAIN_W + 1;
    localparam int PROD_D_W = DIFF_W + GAIN_W + 1;
    localparam int SUM_W    = PROD_D_W + 2;

    localparam int DRIVE_LIMIT = 32767;

    localparam logic [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(6);
    localparam logic [GAIN_W-1:0] GAIN_D_RESET = GAIN_W'(5);

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = CFG_IDX_W'(1);

    localparam logic [MODE_W-1:0] MODE_MOVE_A = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_MOVE_B = MODE_W'(2);

    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic zero_both;
    } lane_ctrl_t;

endpackage

`default_nettype wire

### hdl/dmpd_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module dmpd_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [dmpd_pkg::GAIN_W-1:0]         gain_p,
    input  logic [dmpd_pkg::GAIN_W-1:0]         gain_d,
    input  dmpd_pkg::lane_ctrl_t                ctrl,
    input  logic signed [dmpd_pkg::SPEED_W-1:0] speed,
    input  logic signed [dmpd_pkg::SPEED_W-1:0] target,
    output logic signed [dmpd_pkg::DRIVE_W-1:0] drive
);
    import dmpd_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(DRIVE_LIMIT);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(DRIVE_LIMIT);

    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [ERR_W-1:0]    prev_err_next;
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;
    logic                       zero_reg;
    logic signed [DRIVE_W-1:0]  drive_reg;
    logic signed [DRIVE_W-1:0]  drive_next;

    logic signed [ERR_W-1:0]    err;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_D_W-1:0] prod_d;
    logic signed [SUM_W-1:0]    sum;

    // Stage 1: error, change of error and the two gain products
    always_comb
    begin
        err    = ERR_W'(target) - ERR_W'(speed);
        diff   = DIFF_W'(err) - DIFF_W'(prev_err_reg);
        prod_p = PROD_P_W'(signed'({1'b0, gain_p})) * PROD_P_W'(err);
        prod_d = PROD_D_W'(signed'({1'b0, gain_d})) * PROD_D_W'(diff);
        // keep the last error when both targets are zero
        prev_err_next = ctrl.zero_both ? prev_err_reg : err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
        end
        else if (ctrl.s1_load)
        begin
            prev_err_reg <= prev_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            prod_p_reg <= prod_p;
            prod_d_reg <= prod_d;
            zero_reg   <= ctrl.zero_both;
        end
    end

    // Stage 2: accumulate and clamp, or zero the drive when both targets were zero
    always_comb
    begin
        sum = SUM_W'(drive_reg) + SUM_W'(prod_p_reg) + SUM_W'(prod_d_reg);
        if (zero_reg)
        begin
            drive_next = '0;
        end
        else if (sum > SAT_HI)
        begin
            drive_next = SAT_HI[DRIVE_W-1:0];
        end
        else if (sum < SAT_LO)
        begin
            drive_next = SAT_LO[DRIVE_W-1:0];
        end
        else
        begin
            drive_next = sum[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= '0;
        end
        else if (ctrl.s2_load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

`default_nettype wire

### hdl/dmpd_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module dmpd_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dmpd_pkg::lane_ctrl_t                ctrl,
    input  logic signed [dmpd_pkg::SPEED_W-1:0] speed_left,
    input  logic signed [dmpd_pkg::SPEED_W-1:0] speed_right,
    input  logic [dmpd_pkg::MODE_W-1:0]         car_mode,
    input  logic signed [dmpd_pkg::DRIVE_W-1:0] drive_left,
    input  logic signed [dmpd_pkg::DRIVE_W-1:0] drive_right,
    output logic                                reverse_left,
    output logic [dmpd_pkg::DUTY_W-1:0]         duty_left,
    output logic                                reverse_right,
    output logic [dmpd_pkg::DUTY_W-1:0]         duty_right,
    output logic signed [dmpd_pkg::DIST_W-1:0]  travelled
);
    import dmpd_pkg::*;

    logic signed [SPEED_W:0]   pair_sum;
    logic signed [SPEED_W:0]   pair_half;
    logic signed [SPEED_W-1:0] half_reg;
    logic                      move_reg;
    logic signed [DIST_W-1:0]  dist_reg;
    logic signed [DIST_W-1:0]  dist_next;
    logic signed [DRIVE_W-1:0] mag_left;
    logic signed [DRIVE_W-1:0] mag_right;

    // Halve toward zero: bias negative sums by one before the shift
    always_comb
    begin
        pair_sum  = (SPEED_W+1)'(speed_left) + (SPEED_W+1)'(speed_right);
        pair_half = (pair_sum + (SPEED_W+1)'(pair_sum[SPEED_W])) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            half_reg <= pair_half[SPEED_W-1:0];
            move_reg <= (car_mode == MODE_MOVE_A) || (car_mode == MODE_MOVE_B);
        end
    end

    always_comb
    begin
        dist_next = move_reg ? dist_reg + DIST_W'(half_reg) : dist_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= '0;
        end
        else if (ctrl.s2_load)
        begin
            dist_reg <= dist_next;
        end
    end

    // Drives are clamped to +-32767, so the magnitude always fits the duty field
    always_comb
    begin
        mag_left  = drive_left[DRIVE_W-1]  ? -drive_left  : drive_left;
        mag_right = drive_right[DRIVE_W-1] ? -drive_right : drive_right;
    end

    assign reverse_left  = drive_left[DRIVE_W-1];
    assign duty_left     = mag_left[DUTY_W-1:0];
    assign reverse_right = drive_right[DRIVE_W-1];
    assign duty_right    = mag_right[DUTY_W-1:0];
    assign travelled     = dist_reg;

endmodule

`default_nettype wire

### hdl/dual_motor_incremental_pd_drive.sv
// Two-wheel incremental PD speed drive.
//
// Input channel (in_valid/in_ready): one control tick per transfer, carrying
// the measured speed and the target of each wheel plus the car mode.
// Output channel (out_valid/out_ready): one result per tick, the direction and
// duty of each wheel and the distance travelled so far.
// Configuration: cfg_we writes cfg_data into gain_p (index 0) or gain_d
// (index 1); other indexes are dropped. Write only while no tick is in flight.
//
// out_valid rises once the tick has passed the product stage and the
// accumulate stage. One tick is taken every cycle while the output is not
// stalled: the wheels run in two lanes, each a product stage followed by an
// accumulate-and-clamp stage that closes the drive loop on its own register,
// and the distance runs alongside in the merging stage.
// When out_ready stays low the held result stays on the outputs, one more tick
// waits in the product stage and then in_ready drops.
// Reset clears drives, last errors and distance, and loads gains 6 and 5.
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_incremental_pd_drive (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [dmpd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dmpd_pkg::GAIN_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [dmpd_pkg::SPEED_W-1:0]   speed_left,
    input  logic signed [dmpd_pkg::SPEED_W-1:0]   speed_right,
    input  logic signed [dmpd_pkg::SPEED_W-1:0]   target_left,
    input  logic signed [dmpd_pkg::SPEED_W-1:0]   target_right,
    input  logic [dmpd_pkg::MODE_W-1:0]           car_mode,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  reverse_left,
    output logic [dmpd_pkg::DUTY_W-1:0]           duty_left,
    output logic                                  reverse_right,
    output logic [dmpd_pkg::DUTY_W-1:0]           duty_right,
    output logic signed [dmpd_pkg::DIST_W-1:0]    travelled
);
    import dmpd_pkg::*;

    logic [GAIN_W-1:0] gain_p_reg;
    logic [GAIN_W-1:0] gain_d_reg;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              s2_load;
    logic              s1_load;
    lane_ctrl_t        ctrl;
    logic signed [DRIVE_W-1:0] drive_left;
    logic signed [DRIVE_W-1:0] drive_right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_P_RESET;
            gain_d_reg <= GAIN_D_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P: gain_p_reg <= cfg_data;
                REG_GAIN_D: gain_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance stage 2 when stage 1 holds a tick and the output is empty or being taken
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign s1_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        ctrl.s1_load   = s1_load;
        ctrl.s2_load   = s2_load;
        ctrl.zero_both = (target_left == '0) && (target_right == '0);
    end

    dmpd_lane u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .gain_p (gain_p_reg),
        .gain_d (gain_d_reg),
        .ctrl   (ctrl),
        .speed  (speed_left),
        .target (target_left),
        .drive  (drive_left)
    );

    dmpd_lane u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .gain_p (gain_p_reg),
        .gain_d (gain_d_reg),
        .ctrl   (ctrl),
        .speed  (speed_right),
        .target (target_right),
        .drive  (drive_right)
    );

    dmpd_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .speed_left    (speed_left),
        .speed_right   (speed_right),
        .car_mode      (car_mode),
        .drive_left    (drive_left),
        .drive_right   (drive_right),
        .reverse_left  (reverse_left),
        .duty_left     (duty_left),
        .reverse_right (reverse_right),
        .duty_right    (duty_right),
        .travelled     (travelled)
    );

    assign out_valid = s2_valid_reg;

endmodule

`default_nettype wire

### hdl/dmpd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dmpd_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                reverse_left,
    input  logic [dmpd_pkg::DUTY_W-1:0]         duty_left,
    input  logic                                reverse_right,
    input  logic [dmpd_pkg::DUTY_W-1:0]         duty_right,
    input  logic signed [dmpd_pkg::DIST_W-1:0]  travelled
);
    import dmpd_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty_left)
            && $stable(duty_right) && $stable(travelled))
        else $error("stalled result changed");

    // Input backs up only behind a stalled output
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    // Distance moves only when the output register is free to load
    a_dist_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(travelled) |-> $past(!out_valid || out_ready))
        else $error("distance changed under stall");

    // A reverse drive is never zero
    a_reverse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (reverse_left |-> duty_left != '0) and (reverse_right |-> duty_right != '0))
        else $error("reverse with zero duty");

endmodule

bind dual_motor_incremental_pd_drive dmpd_checker u_dmpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reverse_left  (reverse_left),
    .duty_left     (duty_left),
    .reverse_right (reverse_right),
    .duty_right    (duty_right),
    .travelled     (travelled)
);

`default_nettype wire

### dv/dmpd_drive_checker.sv
`timescale 1ns / 1ps

module dmpd_drive_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dmpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dmpd_pkg::GAIN_W-1:0]         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [dmpd_pkg::SPEED_W-1:0] speed_left,
    input  logic signed [dmpd_pkg::SPEED_W-1:0] speed_right,
    input  logic signed [dmpd_pkg::SPEED_W-1:0] target_left,
    input  logic signed [dmpd_pkg::SPEED_W-1:0] target_right,
    input  logic [dmpd_pkg::MODE_W-1:0]         car_mode,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                reverse_left,
    input  logic [dmpd_pkg::DUTY_W-1:0]         duty_left,
    input  logic                                reverse_right,
    input  logic [dmpd_pkg::DUTY_W-1:0]         duty_right,
    input  logic signed [dmpd_pkg::DIST_W-1:0]  travelled,
    output int                                  fail_count,
    output int                                  outstanding
);
    import dmpd_pkg::*;

    typedef struct {
        logic              rev_l;
        logic [DUTY_W-1:0] duty_l;
        logic              rev_r;
        logic [DUTY_W-1:0] duty_r;
        logic [DIST_W-1:0] trav;
    } drive_out_t;

    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         kd;
    logic signed [DRIVE_W-1:0] drive_l;
    logic signed [DRIVE_W-1:0] drive_r;
    logic signed [ERR_W-1:0]   last_err_l;
    logic signed [ERR_W-1:0]   last_err_r;
    logic [DIST_W-1:0]         distance;
    drive_out_t                expected_drives[$];

    function automatic logic signed [DRIVE_W-1:0] pd_step(
        input logic signed [DRIVE_W-1:0] drive,
        input logic signed [ERR_W-1:0]   err,
        input logic signed [ERR_W-1:0]   last
    );
        longint acc;
        acc = longint'(drive) + longint'(kp) * longint'(err)
            + longint'(kd) * (longint'(err) - longint'(last));
        // clamp symmetric, never wrap
        if (acc > DRIVE_LIMIT)
            acc = DRIVE_LIMIT;
        if (acc < -DRIVE_LIMIT)
            acc = -DRIVE_LIMIT;
        return DRIVE_W'(acc);
    endfunction

    function automatic logic [DUTY_W-1:0] magnitude(input logic signed [DRIVE_W-1:0] drive);
        return DUTY_W'(drive < 0 ? -int'(drive) : int'(drive));
    endfunction

    function automatic drive_out_t advance_drives();
        logic signed [ERR_W-1:0] err_l;
        logic signed [ERR_W-1:0] err_r;
        int                      half;
        drive_out_t              res;
        if (target_left == 0 && target_right == 0) begin
            // stop: zero both drives, keep the last errors
            drive_l = '0;
            drive_r = '0;
        end else begin
            err_l = target_left - speed_left;
            err_r = target_right - speed_right;
            drive_l = pd_step(drive_l, err_l, last_err_l);
            drive_r = pd_step(drive_r, err_r, last_err_r);
            last_err_l = err_l;
            last_err_r = err_r;
        end
        if (car_mode == MODE_MOVE_A || car_mode == MODE_MOVE_B) begin
            half = (int'(speed_left) + int'(speed_right)) / 2;
            distance = distance + DIST_W'(half);
        end
        res.rev_l  = drive_l < 0;
        res.duty_l = magnitude(drive_l);
        res.rev_r  = drive_r < 0;
        res.duty_r = magnitude(drive_r);
        res.trav   = distance;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_out_t want;
        if (!rst_n) begin
            kp          = GAIN_P_RESET;
            kd          = GAIN_D_RESET;
            drive_l     = '0;
            drive_r     = '0;
            last_err_l  = '0;
            last_err_r  = '0;
            distance    = '0;
            fail_count  = 0;
            expected_drives.delete();
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GAIN_P: kp = cfg_data;
                    REG_GAIN_D: kd = cfg_data;
                    default: ;
                endcase
            end
            // compare before predicting so a transfer never meets its own tick
            if (out_valid && out_ready) begin
                if (expected_drives.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, got travelled %0d",
                             $time, travelled);
                    fail_count++;
                end else begin
                    want = expected_drives.pop_front();
                    check_field("reverse_left", want.rev_l, reverse_left);
                    check_field("duty_left", want.duty_l, duty_left);
                    check_field("reverse_right", want.rev_r, reverse_right);
                    check_field("duty_right", want.duty_r, duty_right);
                    check_field("travelled", want.trav, travelled);
                end
            end
            if (in_valid && in_ready)
                expected_drives.push_back(advance_drives());
            outstanding <= expected_drives.size();
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dmpd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 40;
    localparam int PHASES      = 7;
    localparam int PHASE_TICKS = 180;
    localparam int CRUISE_TICKS = 100;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [GAIN_W-1:0]         cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [SPEED_W-1:0] speed_left = '0;
    logic signed [SPEED_W-1:0] speed_right = '0;
    logic signed [SPEED_W-1:0] target_left = '0;
    logic signed [SPEED_W-1:0] target_right = '0;
    logic [MODE_W-1:0]         car_mode = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      reverse_left;
    logic [DUTY_W-1:0]         duty_left;
    logic                      reverse_right;
    logic [DUTY_W-1:0]         duty_right;
    logic signed [DIST_W-1:0]  travelled;

    int fail_count;
    int outstanding;
    int ticks_sent = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit long_hold_done = 1'b0;

    dual_motor_incremental_pd_drive dut (.*);

    dmpd_drive_checker u_checker (.*);

    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("FAIL dual_motor_incremental_pd_drive");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold to fill the pipe
    initial begin
        forever begin
            @(posedge clk);
            if (!long_hold_done && ticks_sent >= 300) begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else
                out_ready <= quiet || ($urandom_range(0, 99) >= 10);
        end
    end

    task automatic send_tick(input logic signed [SPEED_W-1:0] sl,
                             input logic signed [SPEED_W-1:0] sr,
                             input logic signed [SPEED_W-1:0] tl,
                             input logic signed [SPEED_W-1:0] tr,
                             input logic [MODE_W-1:0] mode);
        if (!quiet && $urandom_range(0, 99) < 10) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        speed_left   <= sl;
        speed_right  <= sr;
        target_left  <= tl;
        target_right <= tr;
        car_mode     <= mode;
        // hold until the transfer
        do
            @(posedge clk);
        while (!in_ready);
        ticks_sent++;
    endtask

    task automatic random_tick();
        int                   r;
        int                   tl;
        int                   tr;
        logic [MODE_W-1:0]    mode;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 1))
            mode = $urandom_range(0, 1) ? MODE_MOVE_A : MODE_MOVE_B;
        else
            mode = MODE_W'($urandom);
        if (r < 25) begin
            send_tick(SPEED_W'($urandom), SPEED_W'($urandom), SPEED_W'($urandom),
                      SPEED_W'($urandom), mode);
        end else begin
            tl = int'($urandom_range(0, 4000)) - 2000;
            tr = int'($urandom_range(0, 4000)) - 2000;
            if (r < 35) begin
                tl = 0;
                tr = 0;
            end
            // speed tracks the target with some noise
            send_tick(SPEED_W'(tl + int'($urandom_range(0, 100)) - 50),
                      SPEED_W'(tr + int'($urandom_range(0, 100)) - 50),
                      SPEED_W'(tl), SPEED_W'(tr), mode);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAIN_P;
        cfg_data  <= kp;
        @(posedge clk);
        cfg_index <= REG_GAIN_D;
        cfg_data  <= kd;
        @(posedge clk);
        // out-of-range index must be dropped
        cfg_index <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
        cfg_data  <= GAIN_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        logic [GAIN_W-1:0] phase_kp[PHASES] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd6, 8'd6};
        logic [GAIN_W-1:0] phase_kd[PHASES] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd5, 8'd5};
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] kd;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at reset gains
        send_tick(0, 0, 0, 0, 0);
        send_tick(0, 0, 100, -100, MODE_MOVE_A);
        send_tick(-32768, -32768, 32767, 32767, MODE_MOVE_B);
        send_tick(32767, 32767, -32768, -32768, MODE_MOVE_A);
        send_tick(32767, -32768, 32767, -32768, MODE_MOVE_B);
        send_tick(500, -300, 0, 0, MODE_MOVE_A);
        send_tick(-3, 0, 0, 10, MODE_MOVE_B);
        for (int m = 0; m < 8; m++)
            send_tick(7, -2, 50, -50, MODE_W'(m));
        send_tick(0, 0, 1, 1, 0);
        send_tick(21845, -21846, -21846, 21845, MODE_MOVE_A);
        send_tick(-21846, 21845, 21845, -21846, MODE_MOVE_B);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            kp = (ph < 5) ? phase_kp[ph] : GAIN_W'($urandom);
            kd = (ph < 5) ? phase_kd[ph] : GAIN_W'($urandom);
            configure(kp, kd);
            quiet = (ph == 3);
            repeat (PHASE_TICKS) random_tick();
        end

        // Cruise at top speed so the distance grows fast
        drain();
        configure(GAIN_W'($urandom), GAIN_W'($urandom));
        quiet = 1'b1;
        repeat (CRUISE_TICKS)
            send_tick(32767, 32767, SPEED_W'(int'($urandom_range(0, 200)) - 100),
                      SPEED_W'(int'($urandom_range(0, 200)) - 100),
                      $urandom_range(0, 1) ? MODE_MOVE_A : MODE_MOVE_B);
        quiet = 1'b0;
        repeat (40) random_tick();

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS dual_motor_incremental_pd_drive");
        else
            $display("FAIL dual_motor_incremental_pd_drive");
        $finish;
    end

endmodule

### filelist.f
hdl/dmpd_pkg.sv
hdl/dmpd_lane.sv
hdl/dmpd_merge.sv
hdl/dual_motor_incremental_pd_drive.sv
hdl/dmpd_checker.sv
dv/dmpd_drive_checker.sv
dv/testbench.sv
